// ===== rtl/ssf_pkg.sv =====
// Package for the scope sample framer: shared constants, register indexes,
// the frame record passed from the front end to the back end, and state types.
// No dependencies.
package ssf_pkg;

	// Fixed field formats
	localparam int SAMPLE_W   = 16;   // signed Q8.8 sample, offset and gain
	localparam int MAX_CH     = 8;    // byte lanes in a result beat
	localparam int CH_W       = $clog2(MAX_CH);
	localparam int BYTE_W     = 8;
	localparam int IN_DATA_W  = 136;  // link_up + 8 samples, padded to bytes
	localparam int OUT_DATA_W = 72;   // sync + 8 bytes
	localparam int REG_W      = 64;
	localparam int ADDR_W     = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'd255;
	localparam logic [BYTE_W-1:0] LOW_CLAMP  = 8'd1;
	localparam logic [BYTE_W-1:0] HIGH_CLAMP = 8'd254;
	// 128 in the Q16.16 product domain
	localparam logic signed [33:0] MID_LEVEL = 34'sd8388608;
	localparam logic signed [33:0] ONE_Q16   = 34'sd65536;

	localparam logic [REG_W-1:0] GAIN_RESET = 64'h0100_0100_0100_0100;
	localparam logic [SAMPLE_W-1:0] STEP_RESET = 16'd1;

	// Register indexes (byte address / 8)
	localparam logic [2:0] REG_STEP     = 3'd0;
	localparam logic [2:0] REG_OFFS_LOW = 3'd1;
	localparam logic [2:0] REG_OFFS_HI  = 3'd2;
	localparam logic [2:0] REG_GAIN_LOW = 3'd3;
	localparam logic [2:0] REG_GAIN_HI  = 3'd4;

	// Input beat kinds
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef logic [MAX_CH-1:0][SAMPLE_W-1:0] lanes_t;

	typedef struct packed {
		logic   last;
		lanes_t samples;
	} frame_t;

	typedef enum logic {
		FR_IDLE,
		FR_DRAIN
	} fr_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ISSUE,
		BK_FLUSH,
		BK_HOLD
	} bk_state_t;

endpackage

// ===== rtl/scope_sample_framer.sv =====
// Top level of the scope sample framer: register port, input unpacking and
// the front end, frame queue and back end. Depends on ssf_pkg, ssf_front,
// ssf_queue and ssf_back.

// The framer takes two kinds of input beat, selected by s_tuser. A tick
// (s_tuser 0) carries one signed Q8.8 sample per channel; every
// decimation_step ticks the samples are stored as one frame in a ring of
// RING_FRAMES frames (a step of 0 or 1 stores every tick), and when the ring
// is full the oldest frame is overwritten. A drain (s_tuser 1) empties the
// ring oldest first. If the link is up and the step is nonzero, each frame
// leaves as one output beat: a 255 sync byte, then per channel
// (sample + offset) * gain + 128 truncated toward zero and clamped to 1..254;
// m_tlast marks the final frame of the drain. Otherwise the frames are
// discarded. A tick or a drain is accepted while the front end is idle; a
// drained frame is read out of the ring memory (one registered read port)
// into a two-entry queue once the previous read is pushed and the queue has
// room, and s_tready is low until the last frame is read. The back end works
// serially, since one adder, one multiplier and one clamp are shared by all
// channels, one channel per cycle; that sets the output rate of a drain. The
// result sits in an output register, so the back end keeps working while a
// finished beat waits for m_tready. Registers are written over the APB port
// at byte address 8 * index and should be changed only while the block is
// idle; the offsets and gains are four 16-bit lanes per word, lowest channel
// in the lowest bits.
module scope_sample_framer #(
	parameter int RING_FRAMES = 8,
	parameter int CHANNELS    = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ssf_pkg::ADDR_W-1:0]        paddr,
	input  logic [ssf_pkg::REG_W-1:0]         pwdata,
	output logic [ssf_pkg::REG_W-1:0]         prdata,
	output logic                              pready,
	// Input beats
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata, lowest bit up: link_up [0], sample_0 [16:1], sample_1 [32:17],
	// ... sample_7 [128:113], zero [135:129]
	input  logic [ssf_pkg::IN_DATA_W-1:0]     s_tdata,
	// s_tuser: op (0 tick, 1 drain)
	input  logic                              s_tuser,
	// Result beats
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata, lowest bit up: sync [7:0], byte_0 [15:8], ... byte_7 [71:64]
	output logic [ssf_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	logic [ssf_pkg::SAMPLE_W-1:0] step_q;
	logic [ssf_pkg::REG_W-1:0]    offs_low_q, offs_hi_q, gain_low_q, gain_hi_q;
	logic [2:0]                   reg_index;
	logic                         reg_write;

	ssf_pkg::lanes_t in_samples, offsets, gains;
	ssf_pkg::frame_t push_frame, pop_frame;
	logic q_push, q_full, q_pop, q_empty;

	// The register is written in the access phase of a write; pready never
	// stretches a transfer.
	assign pready    = 1'b1;
	assign reg_index = paddr[5:3];
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ssf_pkg::STEP_RESET;
			offs_low_q <= '0;
			offs_hi_q  <= '0;
			gain_low_q <= ssf_pkg::GAIN_RESET;
			gain_hi_q  <= ssf_pkg::GAIN_RESET;
		end else if (reg_write) begin
			unique case (reg_index)
				ssf_pkg::REG_STEP:     step_q     <= pwdata[ssf_pkg::SAMPLE_W-1:0];
				ssf_pkg::REG_OFFS_LOW: offs_low_q <= pwdata;
				ssf_pkg::REG_OFFS_HI:  offs_hi_q  <= pwdata;
				ssf_pkg::REG_GAIN_LOW: gain_low_q <= pwdata;
				ssf_pkg::REG_GAIN_HI:  gain_hi_q  <= pwdata;
				default: ;  // addresses past the last register are ignored
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			ssf_pkg::REG_STEP:     prdata = ssf_pkg::REG_W'(step_q);
			ssf_pkg::REG_OFFS_LOW: prdata = offs_low_q;
			ssf_pkg::REG_OFFS_HI:  prdata = offs_hi_q;
			ssf_pkg::REG_GAIN_LOW: prdata = gain_low_q;
			ssf_pkg::REG_GAIN_HI:  prdata = gain_hi_q;
			default:               prdata = '0;
		endcase
	end

	// The low word holds channels 0 to 3, so the concatenation lines up
	// with lane order.
	assign offsets = {offs_hi_q, offs_low_q};
	assign gains   = {gain_hi_q, gain_low_q};

	always_comb begin
		for (int i = 0; i < ssf_pkg::MAX_CH; i++) begin
			in_samples[i] = s_tdata[i*ssf_pkg::SAMPLE_W + 1 +: ssf_pkg::SAMPLE_W];
		end
	end

	ssf_front #(
		.RING_FRAMES (RING_FRAMES),
		.CHANNELS    (CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_link    (s_tdata[0]),
		.in_samples (in_samples),
		.step       (step_q),
		.q_push     (q_push),
		.q_frame    (push_frame),
		.q_full     (q_full)
	);

	ssf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_frame (push_frame),
		.full       (q_full),
		.pop        (q_pop),
		.pop_frame  (pop_frame),
		.empty      (q_empty)
	);

	ssf_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_frame  (pop_frame),
		.q_pop    (q_pop),
		.offsets  (offsets),
		.gains    (gains),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/ssf_front.sv =====
// Front end of the scope sample framer: accepts beats, decimates ticks into
// the frame ring memory and reads drained frames out into the frame queue.
// Depends on ssf_pkg.
module ssf_front #(
	parameter int RING_FRAMES = 8,
	parameter int CHANNELS    = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            in_op,
	input  logic                            in_link,
	input  ssf_pkg::lanes_t                 in_samples,
	input  logic [ssf_pkg::SAMPLE_W-1:0]    step,
	output logic                            q_push,
	output ssf_pkg::frame_t                 q_frame,
	input  logic                            q_full
);

	localparam int SLOT_W = $clog2(RING_FRAMES);
	localparam int HELD_W = $clog2(RING_FRAMES + 1);
	localparam int ROW_W  = CHANNELS * ssf_pkg::SAMPLE_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_FRAMES - 1);
	localparam logic [HELD_W-1:0] FULL_HELD = HELD_W'(RING_FRAMES);

	ssf_pkg::fr_state_t state_q, state_d;

	logic [SLOT_W-1:0] write_slot_q, read_slot_q;
	logic [HELD_W-1:0] held_q;
	logic [ssf_pkg::SAMPLE_W-1:0] tick_q;

	logic [ROW_W-1:0] ring_mem [RING_FRAMES];
	logic [ROW_W-1:0] rd_data_s1;
	logic             rd_valid_s1;
	logic             rd_last_s1;

	logic accept, is_tick, store, emit, wr_en, issue;
	logic [SLOT_W-1:0] write_next, read_next;

	assign accept  = in_valid && in_ready;
	assign is_tick = (in_op == ssf_pkg::OP_TICK);
	assign store   = (step <= 16'd1) || (tick_q >= (step - 16'd1));
	assign emit    = in_link && (step != '0);
	assign wr_en   = accept && is_tick && store;
	assign issue   = (state_q == ssf_pkg::FR_DRAIN) && !rd_valid_s1 && !q_full;

	assign write_next = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
	assign read_next  = (read_slot_q == LAST_SLOT) ? '0 : read_slot_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssf_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ssf_pkg::FR_IDLE: begin
				in_ready = 1'b1;
				if (accept && !is_tick && emit && (held_q != '0)) begin
					state_d = ssf_pkg::FR_DRAIN;
				end
			end
			ssf_pkg::FR_DRAIN: begin
				if (issue && (held_q == HELD_W'(1))) begin
					state_d = ssf_pkg::FR_IDLE;
				end
			end
			default: state_d = ssf_pkg::FR_IDLE;
		endcase
	end

	// Ring pointers and the decimation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			read_slot_q  <= '0;
			held_q       <= '0;
			tick_q       <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			priority if (accept && is_tick) begin
				if (store) begin
					write_slot_q <= write_next;
					tick_q       <= '0;
					if (held_q == FULL_HELD) begin
						// Ring full: the oldest frame is dropped.
						read_slot_q <= read_next;
					end else begin
						held_q <= held_q + 1'b1;
					end
				end else begin
					tick_q <= tick_q + 1'b1;
				end
			end else if (accept && !emit) begin
				// Frames are consumed without being sent.
				read_slot_q <= write_slot_q;
				held_q      <= '0;
			end else if (issue) begin
				read_slot_q <= read_next;
				held_q      <= held_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[write_slot_q] <= in_samples[CHANNELS-1:0];
		end
		if (issue) begin
			rd_data_s1 <= ring_mem[read_slot_q];
			rd_last_s1 <= (held_q == HELD_W'(1));
		end
	end

	assign q_push = rd_valid_s1;

	always_comb begin
		q_frame                          = '0;
		q_frame.last                     = rd_last_s1;
		q_frame.samples[CHANNELS-1:0]    = rd_data_s1;
	end

	// A read is only started when the queue can take its data.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> !q_full)
		else $error("frame pushed into a full queue");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_HELD)
		else $error("ring holds more frames than it has slots");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ssf_pkg::FR_DRAIN) |-> (held_q != '0))
		else $error("drain read-out running on an empty ring");

endmodule

// ===== rtl/ssf_queue.sv =====
// Two-entry frame queue between the front end and the back end of the
// scope sample framer. Depends on ssf_pkg.
module ssf_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssf_pkg::frame_t push_frame,
	output logic            full,
	input  logic            pop,
	output ssf_pkg::frame_t pop_frame,
	output logic            empty
);

	localparam int PTR_W = $clog2(ssf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(ssf_pkg::QUEUE_DEPTH + 1);

	ssf_pkg::frame_t entry_q [ssf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full    = (count_q == CNT_W'(ssf_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_frame = entry_q[rd_ptr_q];

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

// ===== rtl/ssf_back.sv =====
// Back end of the scope sample framer: scales one channel per cycle through
// a shared add, multiply and clamp pipeline and holds the finished result beat.
// Depends on ssf_pkg.
module ssf_back #(
	parameter int CHANNELS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  ssf_pkg::frame_t                   q_frame,
	output logic                              q_pop,
	input  ssf_pkg::lanes_t                   offsets,
	input  ssf_pkg::lanes_t                   gains,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ssf_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	localparam logic [ssf_pkg::CH_W-1:0] LAST_CH = ssf_pkg::CH_W'(CHANNELS - 1);

	typedef logic [ssf_pkg::MAX_CH-1:0][ssf_pkg::BYTE_W-1:0] bytes_t;

	ssf_pkg::bk_state_t state_q, state_d;
	ssf_pkg::frame_t    frame_q;
	logic [ssf_pkg::CH_W-1:0] ch_q;

	logic                      v_s1, v_s2;
	logic [ssf_pkg::CH_W-1:0]  ch_s1, ch_s2;
	logic signed [16:0]        sum_s1;
	logic signed [15:0]        gain_s1;
	logic signed [32:0]        prod_s2;

	bytes_t acc_q, out_bytes_q;
	logic   out_valid_q, out_last_q;

	logic issue, load;
	logic signed [33:0] level;
	logic [ssf_pkg::BYTE_W-1:0] clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssf_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		issue   = 1'b0;
		load    = 1'b0;
		unique case (state_q)
			ssf_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ssf_pkg::BK_ISSUE;
				end
			end
			ssf_pkg::BK_ISSUE: begin
				issue = 1'b1;
				if (ch_q == LAST_CH) begin
					state_d = ssf_pkg::BK_FLUSH;
				end
			end
			ssf_pkg::BK_FLUSH: begin
				if (!v_s1 && !v_s2) begin
					state_d = ssf_pkg::BK_HOLD;
				end
			end
			ssf_pkg::BK_HOLD: begin
				if (!out_valid_q || m_tready) begin
					load    = 1'b1;
					state_d = ssf_pkg::BK_IDLE;
				end
			end
			default: state_d = ssf_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (q_pop) begin
				ch_q <= '0;
			end else if (issue) begin
				ch_q <= ch_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stage 3: add the mid level, take the integer part and clamp.
	assign level = 34'(prod_s2) + ssf_pkg::MID_LEVEL;

	always_comb begin
		priority if (level < ssf_pkg::ONE_Q16) begin
			clamped = ssf_pkg::LOW_CLAMP;
		end else if (level[33:16] > 18'(ssf_pkg::HIGH_CLAMP)) begin
			clamped = ssf_pkg::HIGH_CLAMP;
		end else begin
			clamped = level[23:16];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= q_frame;
		end
		// Stage 1: sample plus offset
		ch_s1   <= ch_q;
		sum_s1  <= 17'($signed(frame_q.samples[ch_q])) + 17'($signed(offsets[ch_q]));
		gain_s1 <= $signed(gains[ch_q]);
		// Stage 2: times gain, Q16.16
		ch_s2   <= ch_s1;
		prod_s2 <= 33'(sum_s1) * 33'(gain_s1);
		if (q_pop) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q[ch_s2] <= clamped;
		end
		if (load) begin
			out_bytes_q <= acc_q;
			out_last_q  <= frame_q.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_bytes_q, ssf_pkg::SYNC_BYTE};
	assign m_tlast  = out_last_q;

	a_pipe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (state_q == ssf_pkg::BK_ISSUE || state_q == ssf_pkg::BK_FLUSH))
		else $error("scaling pipeline active outside a frame");

	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_bytes_q[0] != 8'd0 && out_bytes_q[0] != ssf_pkg::SYNC_BYTE))
		else $error("channel byte collides with the sync marker or zero");

endmodule

// ===== bench/ssf_checker.sv =====
// Scoreboard for the scope sample framer: follows register writes, tick and drain beats,
// keeps its own copy of the frame ring and compares every result beat with its prediction.
// Depends on ssf_pkg.
module ssf_checker #(
	parameter int RING_FRAMES = 8,
	parameter int CHANNELS    = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ssf_pkg::ADDR_W-1:0]     paddr,
	input  logic [ssf_pkg::REG_W-1:0]      pwdata,
	input  logic                           pready,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [ssf_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [ssf_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tlast,
	output int unsigned                    mismatches,
	output int unsigned                    pending,
	output int unsigned                    beats_checked,
	output int unsigned                    frames_lost
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]      sync;
		logic [7:0][7:0] lvl;
		logic            last;
	} scope_beat_t;

	logic signed [ssf_pkg::SAMPLE_W-1:0] ring [RING_FRAMES][CHANNELS];
	int unsigned wr_slot, rd_slot, held;
	logic [15:0] tick_cnt;
	logic [15:0] step;
	logic [127:0] offs, gains;
	scope_beat_t level_q [$];
	int unsigned err_cnt, seen_cnt, lost_cnt;

	// (x + offset) * gain in Q16.16, shifted to mid level, truncated and clamped.
	function automatic logic [7:0] scope_level(input logic signed [15:0] x,
			input logic signed [15:0] off, input logic signed [15:0] gain);
		longint acc;
		longint whole;
		acc = (longint'(x) + longint'(off)) * longint'(gain)
			+ longint'(ssf_pkg::MID_LEVEL);
		if (acc < longint'(ssf_pkg::ONE_Q16))
			return ssf_pkg::LOW_CLAMP;
		whole = acc / longint'(ssf_pkg::ONE_Q16);
		if (whole > longint'(ssf_pkg::HIGH_CLAMP))
			return ssf_pkg::HIGH_CLAMP;
		return whole[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		scope_beat_t want, got;
		ssf_pkg::lanes_t smp;
		logic emit;
		if (!arst_n) begin
			wr_slot = 0;
			rd_slot = 0;
			held = 0;
			tick_cnt = '0;
			step = ssf_pkg::STEP_RESET;
			offs = '0;
			gains = {ssf_pkg::GAIN_RESET, ssf_pkg::GAIN_RESET};
			level_q.delete();
			err_cnt = 0;
			seen_cnt = 0;
			lost_cnt = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					ssf_pkg::REG_STEP:     step = pwdata[15:0];
					ssf_pkg::REG_OFFS_LOW: offs[63:0] = pwdata;
					ssf_pkg::REG_OFFS_HI:  offs[127:64] = pwdata;
					ssf_pkg::REG_GAIN_LOW: gains[63:0] = pwdata;
					ssf_pkg::REG_GAIN_HI:  gains[127:64] = pwdata;
					default: ;
				endcase
			end

			// Results first: a beat leaving at this edge never belongs to a drain taken now.
			if (m_tvalid && m_tready) begin
				got.sync = m_tdata[7:0];
				got.lvl = m_tdata[71:8];
				got.last = m_tlast;
				if (level_q.size() == 0) begin
					$error("result beat with nothing expected: tdata %h tlast %b",
						m_tdata, m_tlast);
					err_cnt++;
				end else begin
					want = level_q.pop_front();
					seen_cnt++;
					if (got.sync !== want.sync) begin
						$error("sync: expected %0d, actual %0d", want.sync, got.sync);
						err_cnt++;
					end
					for (int k = 0; k < ssf_pkg::MAX_CH; k++) begin
						if (got.lvl[k] !== want.lvl[k]) begin
							$error("byte_%0d: expected %0d, actual %0d",
								k, want.lvl[k], got.lvl[k]);
							err_cnt++;
						end
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, got.last);
						err_cnt++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == ssf_pkg::OP_TICK) begin
					smp = s_tdata[128:1];
					if (step <= 16'd1 || tick_cnt >= step - 16'd1) begin
						for (int ch = 0; ch < CHANNELS; ch++)
							ring[wr_slot][ch] = smp[ch];
						wr_slot = (wr_slot + 1) % RING_FRAMES;
						// A full ring loses its oldest frame.
						if (held >= RING_FRAMES) begin
							rd_slot = (rd_slot + 1) % RING_FRAMES;
							lost_cnt++;
						end else begin
							held++;
						end
						tick_cnt = '0;
					end else begin
						tick_cnt = tick_cnt + 16'd1;
					end
				end else begin
					emit = s_tdata[0] && (step != 16'd0);
					while (held > 0) begin
						if (emit) begin
							want.sync = ssf_pkg::SYNC_BYTE;
							want.lvl = '0;
							for (int ch = 0; ch < CHANNELS; ch++)
								want.lvl[ch] = scope_level(ring[rd_slot][ch],
									offs[16*ch +: 16], gains[16*ch +: 16]);
							want.last = (held == 1);
							level_q.push_back(want);
						end
						rd_slot = (rd_slot + 1) % RING_FRAMES;
						held--;
					end
				end
			end
		end
		mismatches <= err_cnt;
		pending <= level_q.size();
		beats_checked <= seen_cnt;
		frames_lost <= lost_cnt;
	end

endmodule

// ===== bench/tb.sv =====
// Top of the scope sample framer bench: clock, reset, register writes, tick and drain
// beats, random ready stalls and the verdict. Depends on ssf_pkg, scope_sample_framer
// and ssf_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_FRAMES = 8;
	localparam int CHANNELS    = 8;
	// Cycles allowed after the last result for a discarding drain to finish.
	localparam int SETTLE      = 250;
	// Length of the long receiver hold-off that backs the block up to its input.
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 41;

	logic                           clk;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [ssf_pkg::ADDR_W-1:0]     paddr;
	logic [ssf_pkg::REG_W-1:0]      pwdata;
	logic [ssf_pkg::REG_W-1:0]      prdata;
	logic                           pready;
	logic                           s_tvalid;
	logic                           s_tready;
	// s_tdata, lowest bit up: link_up, sample_0 .. sample_7, zero padding
	logic [ssf_pkg::IN_DATA_W-1:0]  s_tdata;
	// s_tuser: op (tick or drain)
	logic                           s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	// m_tdata, lowest bit up: sync, byte_0 .. byte_7
	logic [ssf_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;

	int unsigned mismatches, pending, beats_checked, frames_lost;

	// Idling controls, changed only between phases.
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_count = 0;
	int unsigned n_ticks = 0;
	int unsigned n_drains = 0;

	// Decimation step of each random phase; zero and the largest step are in the mix.
	int unsigned step_plan [PHASES] = '{1, 3, 0, 1, 2, 65535, 1, 7};

	scope_sample_framer #(
		.RING_FRAMES(RING_FRAMES),
		.CHANNELS   (CHANNELS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	ssf_checker #(
		.RING_FRAMES(RING_FRAMES),
		.CHANNELS   (CHANNELS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.mismatches   (mismatches),
		.pending      (pending),
		.beats_checked(beats_checked),
		.frames_lost  (frames_lost)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run normally ends after well under a millisecond of simulated time; this
	// catches a hung handshake or a result that never comes.
	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver side. A random stall percentage applies except while a hold-off
	// runs; each new hold request from the stimulus starts a fresh count here.
	initial begin : rx_side
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_count != hold_seen) begin
				hold_seen = hold_count;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Samples lean toward the band that unity gain maps inside 1..254, with
	// full-range values and the four corner codes mixed in.
	function automatic logic [15:0] rand_sample();
		logic [15:0] corner [4];
		corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return corner[$urandom_range(3)];
			default: return 16'($urandom_range(0, 16'hFE00)) - 16'h7F00;
		endcase
	endfunction

	function automatic ssf_pkg::lanes_t rand_frame();
		ssf_pkg::lanes_t f;
		for (int ch = 0; ch < ssf_pkg::MAX_CH; ch++)
			f[ch] = rand_sample();
		return f;
	endfunction

	// Four packed Q8.8 lanes; gains mostly stay within +-2.0 and offsets within
	// +-16 so that the outputs are not all clamped.
	function automatic logic [63:0] rand_lanes(input logic is_gain);
		logic [63:0] w;
		for (int k = 0; k < 4; k++) begin
			if ($urandom_range(3) == 0)
				w[16*k +: 16] = 16'($urandom);
			else if (is_gain)
				w[16*k +: 16] = 16'($urandom_range(0, 16'h0400)) - 16'h0200;
			else
				w[16*k +: 16] = 16'($urandom_range(0, 16'h2000)) - 16'h1000;
		end
		return w;
	endfunction

	// One register write: setup cycle, access cycle, then an idle cycle with psel low
	// so that two writes never touch psel twice in the same step.
	task automatic write_reg(input logic [2:0] idx, input logic [ssf_pkg::REG_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [15:0] step, input logic [63:0] offs_lo,
			input logic [63:0] offs_hi, input logic [63:0] gain_lo, input logic [63:0] gain_hi);
		write_reg(ssf_pkg::REG_STEP, {48'd0, step});
		write_reg(ssf_pkg::REG_OFFS_LOW, offs_lo);
		write_reg(ssf_pkg::REG_OFFS_HI, offs_hi);
		write_reg(ssf_pkg::REG_GAIN_LOW, gain_lo);
		write_reg(ssf_pkg::REG_GAIN_HI, gain_hi);
	endtask

	// Offers one beat after a random idle gap and returns at the edge that takes it.
	// tvalid stays high when the next beat follows without a gap.
	task automatic send_beat(input logic op, input logic link, input ssf_pkg::lanes_t smp);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, smp, link};
		do @(posedge clk); while (!s_tready);
		if (op == ssf_pkg::OP_TICK)
			n_ticks++;
		else
			n_drains++;
	endtask

	// A run of ticks closed by a drain; the link is usually up. Returns beats sent.
	task automatic send_burst(input int unsigned n, output int unsigned sent);
		for (int k = 0; k < n; k++)
			send_beat(ssf_pkg::OP_TICK, 1'($urandom), rand_frame());
		send_beat(ssf_pkg::OP_DRAIN, $urandom_range(99) < 85, rand_frame());
		sent = n + 1;
	endtask

	// Stops offering beats and waits until every predicted result has come out,
	// then gives a discarding drain time to finish. The first edge lets the
	// checker's count catch up with a drain taken at the current edge.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned sent;
		int unsigned got;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tuser <= ssf_pkg::OP_TICK;
		s_tdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the settings the block comes out of reset with: unity
		// gain, zero offset, every tick stored. A drain on an empty ring comes first.
		send_beat(ssf_pkg::OP_DRAIN, 1'b1, rand_frame());
		// Full-scale positive clamps high, full-scale negative clamps low.
		send_beat(ssf_pkg::OP_TICK, 1'b0, {ssf_pkg::MAX_CH{16'h7FFF}});
		send_beat(ssf_pkg::OP_TICK, 1'b1, {ssf_pkg::MAX_CH{16'h8000}});
		send_beat(ssf_pkg::OP_TICK, 1'b0, {ssf_pkg::MAX_CH{16'h0000}});
		send_beat(ssf_pkg::OP_TICK, 1'b1, {16'hFF01, 16'h00FF, 16'h8100, 16'h7F00,
			16'hFF80, 16'h0080, 16'hFFFF, 16'h0001});
		send_beat(ssf_pkg::OP_TICK, 1'b0, {4{16'hAAAA, 16'h5555}});
		send_beat(ssf_pkg::OP_DRAIN, 1'b1, {ssf_pkg::MAX_CH{16'hFFFF}});
		// Ten ticks into eight slots: the two oldest frames are overwritten.
		for (int k = 0; k < 10; k++)
			send_beat(ssf_pkg::OP_TICK, 1'($urandom), rand_frame());
		send_beat(ssf_pkg::OP_DRAIN, 1'b1, rand_frame());
		// Link down: the held frames are thrown away and nothing comes out.
		send_beat(ssf_pkg::OP_TICK, 1'b1, rand_frame());
		send_beat(ssf_pkg::OP_TICK, 1'b0, rand_frame());
		send_beat(ssf_pkg::OP_DRAIN, 1'b0, rand_frame());
		wait_drained();

		// Extreme offsets and gains with a step of zero: frames are stored but a
		// drain with the link up still emits nothing.
		write_all(16'd0, 64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_0000_FFFF,
			64'h7FFF_8000_0001_FFFF, 64'h8000_7FFF_FFFF_0000);
		send_beat(ssf_pkg::OP_TICK, 1'b0, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
			16'h7FFF, 16'h8000, 16'h0000, 16'h0100});
		send_beat(ssf_pkg::OP_DRAIN, 1'b1, rand_frame());
		wait_drained();

		// Step of four, two ticks counted, then the step drops to two:
		// the next tick is stored at once.
		write_reg(ssf_pkg::REG_STEP, 64'd4);
		send_beat(ssf_pkg::OP_TICK, 1'b0, rand_frame());
		send_beat(ssf_pkg::OP_TICK, 1'b1, rand_frame());
		wait_drained();
		write_reg(ssf_pkg::REG_STEP, 64'd2);
		send_beat(ssf_pkg::OP_TICK, 1'b0, {16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
			16'h0100, 16'hFF00, 16'h7FFF, 16'h8000});
		send_beat(ssf_pkg::OP_DRAIN, 1'b1, rand_frame());
		wait_drained();

		// Random phases. Each phase picks its idling mode, writes all registers
		// while the block is idle, then sends runs of ticks closed by drains.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct = 69;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct = 69;
				end
				default: begin
					tx_idle_pct = 36;
					rx_stall_pct = 36;
				end
			endcase
			write_all(16'(step_plan[ph]), rand_lanes(1'b0), rand_lanes(1'b0),
				rand_lanes(1'b1), rand_lanes(1'b1));
			sent = 0;
			if (ph == 0) begin
				// Long receiver hold-off while full rings keep being drained: the
				// output register and queue fill up and the input is held off.
				hold_count <= hold_count + 1;
				for (int k = 0; k < 3; k++) begin
					send_burst(9, got);
					sent += got;
				end
			end
			while (sent < PHASE_BEATS) begin
				send_burst($urandom_range(0, 11), got);
				sent += got;
			end
			wait_drained();
		end

		$display("covered %0d ticks and %0d drains, %0d register settings, four idling modes;",
			n_ticks, n_drains, PHASES + 4);
		$display("%0d result beats compared, %0d frames overwritten on a full ring",
			beats_checked, frames_lost);
		if (mismatches == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
